>>> src/dsg_pkg.sv
// shared types and constants for the step governor
package dsg_pkg;

    localparam int PCT_W      = 7;
    localparam int FREQ_W     = 24;
    localparam int STEP_W     = 25;
    localparam int DSTEP_W    = STEP_W + 1;
    localparam int PROD_W     = PCT_W + FREQ_W;
    localparam int QUOT_IN_W  = PROD_W - 2;
    localparam int RECIP_W    = 31;
    localparam int RECIP_SH   = 35;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;
    localparam int SETTLE_W   = 2;

    // ceil(2^35 / 25): divides by 25 after the divide by 4 shift
    localparam logic [RECIP_W-1:0] RECIP_25  = 31'h51EB851F;
    localparam logic [4:0]         DIV_25    = 5'd25;
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_UP_THR    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DOWN_THR  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_UP_PCT    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DOWN_PCT  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SLEEP_PCT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MIN_FREQ  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MAX_FREQ  = 3'd6;

    localparam logic REL_H = 1'b0;
    localparam logic REL_L = 1'b1;

    typedef struct packed {
        logic [PCT_W-1:0]  up_thr;
        logic [PCT_W-1:0]  down_thr;
        logic [FREQ_W-1:0] min_freq;
        logic [FREQ_W-1:0] max_freq;
        logic [STEP_W-1:0] up_step;
        logic [STEP_W-1:0] down_step;
        logic [STEP_W-1:0] sleep_cap;
    } t_step_cfg;

    typedef struct packed {
        logic              issue;
        logic              relation;
        logic [FREQ_W-1:0] target;
    } t_step_res;

endpackage

>>> src/dsg_pct_scale.sv
// percent of max frequency: pct * max / 100 over three register stages
module dsg_pct_scale
    import dsg_pkg::*;
(
    input  logic              i_clk,
    input  logic [PCT_W-1:0]  i_pct,
    input  logic [FREQ_W-1:0] i_max,
    output logic [STEP_W-1:0] o_value
);

    logic [PROD_W-1:0]           r_prod;
    logic [QUOT_IN_W-1:0]        r_x;
    logic [STEP_W-1:0]           r_qest;
    logic [STEP_W-1:0]           r_value;
    logic [QUOT_IN_W+RECIP_W-1:0] w_recip_prod;
    logic [QUOT_IN_W:0]          w_back;

    // divide by 4 first, then by 25 through the reciprocal
    assign w_recip_prod = {{RECIP_W{1'b0}}, r_prod[PROD_W-1:2]}
                        * {{QUOT_IN_W{1'b0}}, RECIP_25};
    assign w_back = (QUOT_IN_W+1)'(r_qest) * (QUOT_IN_W+1)'(DIV_25);

    always_ff @(posedge i_clk) begin
        r_prod  <= PROD_W'(i_pct) * PROD_W'(i_max);
        r_x     <= r_prod[PROD_W-1:2];
        r_qest  <= w_recip_prod[RECIP_SH +: STEP_W];
        // estimate can only be one high
        if (w_back > {1'b0, r_x}) begin
            r_value <= r_qest - STEP_W'(1);
        end else begin
            r_value <= r_qest;
        end
    end

    assign o_value = r_value;

endmodule

>>> src/dsg_step_calc.sv
// next requested frequency for one sampling tick
module dsg_step_calc
    import dsg_pkg::*;
(
    input  t_step_cfg         i_cfg,
    input  logic [FREQ_W-1:0] i_requested,
    input  logic [PCT_W-1:0]  i_load,
    input  logic              i_awake,
    input  logic [FREQ_W-1:0] i_cur,
    output t_step_res         o_res
);

    logic [FREQ_W-1:0]  w_base;
    logic [DSTEP_W-1:0] w_up_sum;
    logic [FREQ_W-1:0]  w_up_val;
    logic [DSTEP_W-1:0] w_dstep;
    logic [FREQ_W-1:0]  w_dn_raw;
    logic [STEP_W-1:0]  w_cap;
    logic [FREQ_W-1:0]  w_dn_val;
    logic               w_up;
    logic               w_dn;

    always_comb begin
        // out of range (or inverted range) falls back to the running frequency
        if (i_requested > i_cfg.max_freq || i_requested < i_cfg.min_freq) begin
            w_base = i_cur;
        end else begin
            w_base = i_requested;
        end

        w_up_sum = DSTEP_W'(w_base) + DSTEP_W'(i_cfg.up_step);
        if (w_up_sum > DSTEP_W'(i_cfg.max_freq)) begin
            w_up_val = i_cfg.max_freq;
        end else begin
            w_up_val = w_up_sum[FREQ_W-1:0];
        end

        w_dstep = i_awake ? DSTEP_W'(i_cfg.down_step) : {i_cfg.down_step, 1'b0};
        if (DSTEP_W'(w_base) > w_dstep) begin
            w_dn_raw = w_base - w_dstep[FREQ_W-1:0];
        end else begin
            w_dn_raw = i_cfg.min_freq;
        end

        if (STEP_W'(i_cfg.min_freq) > i_cfg.sleep_cap) begin
            w_cap = STEP_W'(i_cfg.min_freq);
        end else begin
            w_cap = i_cfg.sleep_cap;
        end
        if (!i_awake && STEP_W'(w_dn_raw) > w_cap) begin
            w_dn_val = w_cap[FREQ_W-1:0];
        end else begin
            w_dn_val = w_dn_raw;
        end

        w_up = i_awake && (i_load > i_cfg.up_thr);
        w_dn = !i_awake || (i_load < i_cfg.down_thr);

        if (w_up) begin
            o_res.issue    = 1'b1;
            o_res.relation = REL_H;
            o_res.target   = w_up_val;
        end else if (w_dn) begin
            o_res.issue    = 1'b1;
            o_res.relation = REL_L;
            o_res.target   = w_dn_val;
        end else begin
            o_res.issue    = 1'b0;
            o_res.relation = REL_H;
            o_res.target   = '0;
        end
    end

endmodule

>>> src/dvfs_step_governor.sv
// step frequency governor top level: register port, input and result registers
// requests pass an input register and an output stage, which also closes the
// requested-frequency loop; one request per cycle while the master side does not stall
// after reset and after every register write, s_axis_tready stays low
// while the three percent-of-max steps pass their 3-stage multiply pipelines
// reset (synchronous, active low) loads register defaults and clears requested to 0
module dvfs_step_governor
    import dsg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // apb register port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // sampling ticks
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,  // [6:0] load_percent, [30:7] current_freq
    input  logic                  s_axis_tuser,  // [0] display awake flag
    // frequency requests
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,  // [23:0] target_freq
    output logic [1:0]            m_axis_tuser   // [0] issue, [1] relation
);

    logic [PCT_W-1:0]     r_up_thr;
    logic [PCT_W-1:0]     r_down_thr;
    logic [PCT_W-1:0]     r_up_pct;
    logic [PCT_W-1:0]     r_down_pct;
    logic [PCT_W-1:0]     r_sleep_pct;
    logic [FREQ_W-1:0]    r_min;
    logic [FREQ_W-1:0]    r_max;
    logic [SETTLE_W-1:0]  r_settle;
    logic [STEP_W-1:0]    w_up_step;
    logic [STEP_W-1:0]    w_down_step;
    logic [STEP_W-1:0]    w_sleep_cap;
    logic                 r_in_valid;
    logic [PCT_W-1:0]     r_load;
    logic                 r_awake;
    logic [FREQ_W-1:0]    r_cur;
    logic                 r_out_valid;
    t_step_res            r_res;
    logic [FREQ_W-1:0]    r_requested;
    logic                 w_cfg_wr;
    logic [REG_IDX_W-1:0] w_idx;
    logic                 w_advance;
    logic                 w_in_acc;
    t_step_cfg            w_cfg;
    t_step_res            w_res;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_idx     = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_thr    <= PCT_W'(90);
            r_down_thr  <= PCT_W'(50);
            r_up_pct    <= PCT_W'(3);
            r_down_pct  <= PCT_W'(15);
            r_sleep_pct <= PCT_W'(25);
            r_min       <= '0;
            r_max       <= '1;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                REG_UP_THR:    r_up_thr    <= pwdata[PCT_W-1:0];
                REG_DOWN_THR:  r_down_thr  <= pwdata[PCT_W-1:0];
                REG_UP_PCT:    r_up_pct    <= pwdata[PCT_W-1:0];
                REG_DOWN_PCT:  r_down_pct  <= pwdata[PCT_W-1:0];
                REG_SLEEP_PCT: r_sleep_pct <= pwdata[PCT_W-1:0];
                REG_MIN_FREQ:  r_min       <= pwdata[FREQ_W-1:0];
                REG_MAX_FREQ:  r_max       <= pwdata[FREQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_UP_THR:    prdata = 32'(r_up_thr);
            REG_DOWN_THR:  prdata = 32'(r_down_thr);
            REG_UP_PCT:    prdata = 32'(r_up_pct);
            REG_DOWN_PCT:  prdata = 32'(r_down_pct);
            REG_SLEEP_PCT: prdata = 32'(r_sleep_pct);
            REG_MIN_FREQ:  prdata = 32'(r_min);
            REG_MAX_FREQ:  prdata = 32'(r_max);
            default:       prdata = '0;
        endcase
    end

    // hold off requests until the step pipelines reflect the registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_wr) begin
            r_settle <= SETTLE_CYCLES;
        end else if (r_settle != '0) begin
            r_settle <= r_settle - SETTLE_W'(1);
        end
    end

    dsg_pct_scale u_up_scale (
        .i_clk   (i_clk),
        .i_pct   (r_up_pct),
        .i_max   (r_max),
        .o_value (w_up_step)
    );

    dsg_pct_scale u_down_scale (
        .i_clk   (i_clk),
        .i_pct   (r_down_pct),
        .i_max   (r_max),
        .o_value (w_down_step)
    );

    dsg_pct_scale u_sleep_scale (
        .i_clk   (i_clk),
        .i_pct   (r_sleep_pct),
        .i_max   (r_max),
        .o_value (w_sleep_cap)
    );

    assign w_cfg.up_thr    = r_up_thr;
    assign w_cfg.down_thr  = r_down_thr;
    assign w_cfg.min_freq  = r_min;
    assign w_cfg.max_freq  = r_max;
    assign w_cfg.up_step   = w_up_step;
    assign w_cfg.down_step = w_down_step;
    assign w_cfg.sleep_cap = w_sleep_cap;

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_settle == '0) && (!r_in_valid || w_advance);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_load  <= s_axis_tdata[PCT_W-1:0];
            r_cur   <= s_axis_tdata[PCT_W +: FREQ_W];
            r_awake <= s_axis_tuser;
        end
    end

    dsg_step_calc u_calc (
        .i_cfg       (w_cfg),
        .i_requested (r_requested),
        .i_load      (r_load),
        .i_awake     (r_awake),
        .i_cur       (r_cur),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_requested <= '0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid && w_res.issue) begin
                r_requested <= w_res.target;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_res <= w_res;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_res.target;
    assign m_axis_tuser[0] = r_res.issue;
    assign m_axis_tuser[1] = r_res.relation;

`ifndef SYNTH
    a_settle_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_settle != '0) |-> !s_axis_tready)
        else $error("request taken while step pipelines settle");

    a_idle_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
        else $error("no-step result carries a target or relation");

    a_up_within_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1] == REL_H)
        |-> (m_axis_tdata <= r_max))
        else $error("step-up target above max frequency");

    a_req_moves_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_requested)) |-> $past(r_in_valid && w_advance))
        else $error("requested frequency changed without a result");
`endif

endmodule
